// ===== hw/rtl/renacc_pkg.sv =====
// ----------------------------------------------------------------------------
// renacc_pkg
// shared types, constants and helpers of the relative error norm accumulator
// ----------------------------------------------------------------------------
package renacc_pkg;

  // sample format and lane count
  localparam int unsigned COMPONENTS   = 3;
  localparam int unsigned SAMPLE_WIDTH = 32;
  localparam int unsigned NUM_LANES    = 3;
  localparam int unsigned USED_LANES   = (COMPONENTS > 3) ? 3 : ((COMPONENTS < 1) ? 1 : COMPONENTS);

  typedef struct packed {
    logic signed [31:0] approx_x;
    logic signed [31:0] approx_y;
    logic signed [31:0] approx_z;
    logic signed [31:0] exact_x;
    logic signed [31:0] exact_y;
    logic signed [31:0] exact_z;
    logic        [31:0] weight;
    logic               last_sample;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] error_x;
    logic signed [31:0] error_y;
    logic signed [31:0] error_z;
    logic               norms_valid;
    logic        [31:0] rel_l1;
    logic        [31:0] rel_l2;
    logic        [31:0] rel_linf;
    logic               divide_fault;
  } result_t;

  typedef struct packed {
    logic vector_mode;
  } cfg_t;

  // what one lane hands to the merging stage
  typedef struct packed {
    logic signed [31:0] err;
    logic        [31:0] err_abs;
    logic        [31:0] exact_abs;
    logic        [63:0] err_sq;
    logic        [63:0] exact_sq;
  } lane_res_t;

  // handshake of an iterative unit
  typedef struct packed {
    logic start;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic logic [31:0] clamp32(input logic [63:0] v);
    return (v[63:32] != 32'd0) ? {32{1'b1}} : v[31:0];
  endfunction

endpackage

// ===== hw/rtl/renacc_in_if.sv =====
// ----------------------------------------------------------------------------
// renacc_in_if
// sample channel: valid, ready and one sample item
// ----------------------------------------------------------------------------
interface renacc_in_if import renacc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/renacc_out_if.sv =====
// ----------------------------------------------------------------------------
// renacc_out_if
// result channel: valid, ready and one result item
// ----------------------------------------------------------------------------
interface renacc_out_if import renacc_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/renacc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// renacc_cfg_if
// register write channel: valid, ready and the mode register data
// ----------------------------------------------------------------------------
interface renacc_cfg_if import renacc_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/relative_error_norm_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// relative_error_norm_accumulator_unit
// weighted relative L1, L2 and Linf error norms over a stream of samples
// ----------------------------------------------------------------------------
// Each sample item gives one result item carrying the saturated per-component
// error. Three lanes work on the x, y and z components side by side and a
// merging stage adds their squares; vector magnitudes come from a shared
// bit-serial square root, the weighted terms from one shared 32x32 multiplier
// stepped over eight products. One item is in flight at a time. The last
// sample of a set runs up to three fractional divides, the L2 quotient
// passing through a further square root, before its result carries the norms
// and the sums clear. The result sits in an output register, so the next item
// is taken while it waits.
module relative_error_norm_accumulator_unit import renacc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  renacc_cfg_if.sink    cfg_i,
  renacc_in_if.sink     in_i,
  renacc_out_if.source  out_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_LANE, ST_SQ, ST_SUM, ST_RT_E, ST_RT_E_W, ST_RT_X, ST_RT_X_W,
    ST_MUL, ST_SCALE, ST_ACC, ST_DIV, ST_DIV_W, ST_RT_N, ST_RT_N_W, ST_DONE
  } state_e;

  state_e state_q;

  // mode register
  logic vector_mode_q;

  // captured sample
  sample_t smp_q;

  // accumulators
  logic [63:0] err_abs_sum_q, exact_abs_sum_q, err_sq_sum_q, exact_sq_sum_q;
  logic [31:0] err_peak_q, exact_peak_q;

  // per-item working registers
  logic [63:0] esum_q, xsum_q;
  logic [31:0] emag_q, xmag_q;
  logic [3:0]  step_q;
  logic [63:0] mul_q;
  logic [63:0] eabs_p_q, xabs_p_q, esq_q, xsq_q;
  logic [63:0] ea_q, eb_q, xa_q, xb_q;
  logic [63:0] esc_q, xsc_q;
  logic [1:0]  sel_q;
  logic [31:0] l1_q, l2_q, linf_q;
  logic        fault_q;

  // output register
  logic    out_valid_q;
  result_t out_data_q;

  // lanes
  lane_res_t lane_res [NUM_LANES];
  logic      lane_en;
  logic signed [31:0] lane_a [NUM_LANES];
  logic signed [31:0] lane_x [NUM_LANES];

  assign lane_a[0] = smp_q.approx_x;
  assign lane_a[1] = smp_q.approx_y;
  assign lane_a[2] = smp_q.approx_z;
  assign lane_x[0] = smp_q.exact_x;
  assign lane_x[1] = smp_q.exact_y;
  assign lane_x[2] = smp_q.exact_z;
  assign lane_en   = (state_q == ST_LANE);

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    // scalar mode uses the x lane alone
    logic used;
    assign used = (g == 0) || (vector_mode_q && (g < USED_LANES));
    renacc_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (lane_en),
      .used_i   (used),
      .approx_i (lane_a[g]),
      .exact_i  (lane_x[g]),
      .res_o    (lane_res[g])
    );
  end

  // merging stage: sum of squared magnitudes over the lanes
  logic [63:0] esum_d, xsum_d;
  assign esum_d = lane_res[0].err_sq + lane_res[1].err_sq + lane_res[2].err_sq;
  assign xsum_d = lane_res[0].exact_sq + lane_res[1].exact_sq + lane_res[2].exact_sq;

  // shared square root
  unit_ctl_t   sq_ctl;
  unit_sts_t   sq_sts;
  logic [63:0] sq_op;
  logic [31:0] sq_root;
  logic [63:0] quo_q;

  assign sq_ctl.start = (state_q == ST_RT_E) || (state_q == ST_RT_X) || (state_q == ST_RT_N);

  always_comb begin
    case (state_q)
      ST_RT_E: sq_op = esum_q;
      ST_RT_X: sq_op = xsum_q;
      default: sq_op = quo_q;
    endcase
  end

  renacc_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sq_ctl),
    .op_i   (sq_op),
    .sts_o  (sq_sts),
    .root_o (sq_root)
  );

  // shared divider: l1, then l2 before its root, then linf
  unit_ctl_t   dv_ctl;
  unit_sts_t   dv_sts;
  logic [63:0] dv_num, dv_den, dv_quo;
  logic        dv_f16;

  always_comb begin
    case (sel_q)
      2'd0: begin
        dv_num = err_abs_sum_q;
        dv_den = exact_abs_sum_q;
        dv_f16 = 1'b1;
      end
      2'd1: begin
        dv_num = err_sq_sum_q;
        dv_den = exact_sq_sum_q;
        dv_f16 = 1'b0;
      end
      default: begin
        dv_num = {32'd0, err_peak_q};
        dv_den = {32'd0, exact_peak_q};
        dv_f16 = 1'b1;
      end
    endcase
  end

  assign dv_ctl.start = (state_q == ST_DIV) && (dv_den != 64'd0);

  renacc_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (dv_ctl),
    .frac16_i (dv_f16),
    .num_i    (dv_num),
    .den_i    (dv_den),
    .sts_o    (dv_sts),
    .quo_o    (dv_quo)
  );

  // shared multiplier operands, one product a step
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    case (step_q)
      4'd0:    begin mul_a = emag_q;        mul_b = smp_q.weight; end
      4'd1:    begin mul_a = emag_q;        mul_b = emag_q;       end
      4'd2:    begin mul_a = xmag_q;        mul_b = smp_q.weight; end
      4'd3:    begin mul_a = xmag_q;        mul_b = xmag_q;       end
      4'd4:    begin mul_a = esq_q[63:32];  mul_b = smp_q.weight; end
      4'd5:    begin mul_a = esq_q[31:0];   mul_b = smp_q.weight; end
      4'd6:    begin mul_a = xsq_q[63:32];  mul_b = smp_q.weight; end
      4'd7:    begin mul_a = xsq_q[31:0];   mul_b = smp_q.weight; end
      default: begin mul_a = '0;            mul_b = '0;           end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // weighted square term: (sq_hi * w) << 2 plus (sq_lo * w) >> 30, saturating
  logic [63:0] esc_d, xsc_d;
  assign esc_d = (ea_q[63:62] != 2'b00) ? {64{1'b1}} :
                 sat_add({ea_q[61:0], 2'b00}, {30'd0, eb_q[63:30]});
  assign xsc_d = (xa_q[63:62] != 2'b00) ? {64{1'b1}} :
                 sat_add({xa_q[61:0], 2'b00}, {30'd0, xb_q[63:30]});

  // handshakes
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      vector_mode_q   <= 1'b0;
      smp_q           <= '0;
      err_abs_sum_q   <= '0;
      exact_abs_sum_q <= '0;
      err_sq_sum_q    <= '0;
      exact_sq_sum_q  <= '0;
      err_peak_q      <= '0;
      exact_peak_q    <= '0;
      esum_q          <= '0;
      xsum_q          <= '0;
      emag_q          <= '0;
      xmag_q          <= '0;
      step_q          <= '0;
      mul_q           <= '0;
      eabs_p_q        <= '0;
      xabs_p_q        <= '0;
      esq_q           <= '0;
      xsq_q           <= '0;
      ea_q            <= '0;
      eb_q            <= '0;
      xa_q            <= '0;
      xb_q            <= '0;
      esc_q           <= '0;
      xsc_q           <= '0;
      sel_q           <= '0;
      quo_q           <= '0;
      l1_q            <= '0;
      l2_q            <= '0;
      linf_q          <= '0;
      fault_q         <= 1'b0;
      out_valid_q     <= 1'b0;
      out_data_q      <= '0;
    end else begin
      if (cfg_i.valid) begin
        vector_mode_q <= cfg_i.data.vector_mode;
      end
      // a waiting result leaves unless a new one is loaded in its place
      if (out_valid_q && out_o.ready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            smp_q   <= in_i.data;
            l1_q    <= '0;
            l2_q    <= '0;
            linf_q  <= '0;
            fault_q <= 1'b0;
            state_q <= ST_LANE;
          end
        end
        ST_LANE: state_q <= ST_SQ;
        ST_SQ:   state_q <= ST_SUM;
        ST_SUM: begin
          esum_q <= esum_d;
          xsum_q <= xsum_d;
          emag_q <= lane_res[0].err_abs;
          xmag_q <= lane_res[0].exact_abs;
          step_q <= '0;
          state_q <= vector_mode_q ? ST_RT_E : ST_MUL;
        end
        ST_RT_E: state_q <= ST_RT_E_W;
        ST_RT_E_W: begin
          if (sq_sts.done) begin
            emag_q  <= sq_root;
            state_q <= ST_RT_X;
          end
        end
        ST_RT_X: state_q <= ST_RT_X_W;
        ST_RT_X_W: begin
          if (sq_sts.done) begin
            xmag_q  <= sq_root;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          mul_q  <= mul_p;
          step_q <= step_q + 4'd1;
          // pick up the product of the previous step
          case (step_q)
            4'd1: eabs_p_q <= {14'd0, mul_q[63:14]};
            4'd2: esq_q    <= mul_q;
            4'd3: xabs_p_q <= {14'd0, mul_q[63:14]};
            4'd4: xsq_q    <= mul_q;
            4'd5: ea_q     <= mul_q;
            4'd6: eb_q     <= mul_q;
            4'd7: xa_q     <= mul_q;
            4'd8: begin
              xb_q    <= mul_q;
              state_q <= ST_SCALE;
            end
            default: ;
          endcase
        end
        ST_SCALE: begin
          esc_q   <= esc_d;
          xsc_q   <= xsc_d;
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          err_abs_sum_q   <= sat_add(err_abs_sum_q, eabs_p_q);
          exact_abs_sum_q <= sat_add(exact_abs_sum_q, xabs_p_q);
          err_sq_sum_q    <= sat_add(err_sq_sum_q, esc_q);
          exact_sq_sum_q  <= sat_add(exact_sq_sum_q, xsc_q);
          if (emag_q > err_peak_q) begin
            err_peak_q <= emag_q;
          end
          if (xmag_q > exact_peak_q) begin
            exact_peak_q <= xmag_q;
          end
          sel_q   <= '0;
          state_q <= smp_q.last_sample ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          if (dv_den == 64'd0) begin
            // zero denominator: norm stays zero, flag the fault
            fault_q <= 1'b1;
            sel_q   <= sel_q + 2'd1;
            state_q <= (sel_q == 2'd2) ? ST_DONE : ST_DIV;
          end else begin
            state_q <= ST_DIV_W;
          end
        end
        ST_DIV_W: begin
          if (dv_sts.done) begin
            case (sel_q)
              2'd0: begin
                l1_q    <= clamp32(dv_quo);
                sel_q   <= 2'd1;
                state_q <= ST_DIV;
              end
              2'd1: begin
                quo_q   <= dv_quo;
                state_q <= ST_RT_N;
              end
              default: begin
                linf_q  <= clamp32(dv_quo);
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_RT_N: state_q <= ST_RT_N_W;
        ST_RT_N_W: begin
          if (sq_sts.done) begin
            l2_q    <= sq_root;
            sel_q   <= 2'd2;
            state_q <= ST_DIV;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q              <= 1'b1;
            out_data_q.error_x       <= lane_res[0].err;
            out_data_q.error_y       <= lane_res[1].err;
            out_data_q.error_z       <= lane_res[2].err;
            out_data_q.norms_valid   <= smp_q.last_sample;
            out_data_q.rel_l1        <= l1_q;
            out_data_q.rel_l2        <= l2_q;
            out_data_q.rel_linf      <= linf_q;
            out_data_q.divide_fault  <= fault_q;
            if (smp_q.last_sample) begin
              err_abs_sum_q   <= '0;
              exact_abs_sum_q <= '0;
              err_sq_sum_q    <= '0;
              exact_sq_sum_q  <= '0;
              err_peak_q      <= '0;
              exact_peak_q    <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/renacc_lane.sv =====
// ----------------------------------------------------------------------------
// renacc_lane
// one component: saturated error, magnitudes and their squares
// ----------------------------------------------------------------------------
module renacc_lane import renacc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               used_i,
  input  logic signed [31:0] approx_i,
  input  logic signed [31:0] exact_i,
  output lane_res_t          res_o
);
  localparam int unsigned Shift = 32 - SAMPLE_WIDTH;

  logic signed [31:0] a_sh, x_sh, a_s, x_s;
  logic signed [32:0] diff;
  logic signed [31:0] err_sat;
  logic        [31:0] err_abs, x_abs;
  logic signed [31:0] err_q;
  logic        [31:0] err_abs_q, x_abs_q;
  logic        [63:0] err_sq_q, x_sq_q;

  // sign extension from the sample width
  assign a_sh = approx_i <<< Shift;
  assign x_sh = exact_i <<< Shift;
  assign a_s  = a_sh >>> Shift;
  assign x_s  = x_sh >>> Shift;

  assign diff = 33'(a_s) - 33'(x_s);

  always_comb begin
    if (diff > 33'sh0_7FFF_FFFF) begin
      err_sat = 32'sh7FFF_FFFF;
    end else if (diff < -33'sh0_8000_0000) begin
      err_sat = -32'sh8000_0000;
    end else begin
      err_sat = diff[31:0];
    end
  end

  assign err_abs = err_sat[31] ? (32'd0 - 32'(err_sat)) : 32'(err_sat);
  assign x_abs   = x_s[31] ? (32'd0 - 32'(x_s)) : 32'(x_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q     <= '0;
      err_abs_q <= '0;
      x_abs_q   <= '0;
      err_sq_q  <= '0;
      x_sq_q    <= '0;
    end else begin
      if (en_i) begin
        err_q     <= used_i ? err_sat : 32'sd0;
        err_abs_q <= used_i ? err_abs : 32'd0;
        x_abs_q   <= used_i ? x_abs : 32'd0;
      end
      // squares follow in the cycle after the magnitudes
      err_sq_q <= 64'(err_abs_q) * 64'(err_abs_q);
      x_sq_q   <= 64'(x_abs_q) * 64'(x_abs_q);
    end
  end

  assign res_o.err       = err_q;
  assign res_o.err_abs   = err_abs_q;
  assign res_o.exact_abs = x_abs_q;
  assign res_o.err_sq    = err_sq_q;
  assign res_o.exact_sq  = x_sq_q;
endmodule

// ===== hw/rtl/renacc_isqrt.sv =====
// ----------------------------------------------------------------------------
// renacc_isqrt
// truncated square root of a 64 bit value, one result bit a cycle
// ----------------------------------------------------------------------------
module renacc_isqrt import renacc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  unit_ctl_t   ctl_i,
  input  logic [63:0] op_i,
  output unit_sts_t   sts_o,
  output logic [31:0] root_o
);
  logic [63:0] n_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [35:0] rem_sh, trial, rem_sub;
  logic        take;

  assign rem_sh  = {rem_q, n_q[63:62]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign take    = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        n_q    <= op_i;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= 6'd32;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        n_q    <= {n_q[61:0], 2'b00};
        rem_q  <= take ? rem_sub[33:0] : rem_sh[33:0];
        root_q <= {root_q[30:0], take};
        cnt_q  <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign root_o     = root_q;
endmodule

// ===== hw/rtl/renacc_div.sv =====
// ----------------------------------------------------------------------------
// renacc_div
// fractional divide floor(num * 2^f / den), f 16 or 32, saturated to 64 bits
// ----------------------------------------------------------------------------
module renacc_div import renacc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  unit_ctl_t   ctl_i,
  input  logic        frac16_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output unit_sts_t   sts_o,
  output logic [63:0] quo_o
);
  logic [95:0] dvd_q;
  logic [63:0] den_q, rem_q, quo_q;
  logic        ovf_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;
  logic [64:0] r, r_sub;
  logic        ge;

  assign r     = {rem_q, dvd_q[95]};
  assign ge    = r >= {1'b0, den_q};
  assign r_sub = r - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        dvd_q  <= {num_i, 32'd0};
        den_q  <= den_i;
        rem_q  <= '0;
        quo_q  <= '0;
        ovf_q  <= 1'b0;
        cnt_q  <= frac16_i ? 7'd80 : 7'd96;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        dvd_q <= {dvd_q[94:0], 1'b0};
        rem_q <= ge ? r_sub[63:0] : r[63:0];
        quo_q <= {quo_q[62:0], ge};
        ovf_q <= ovf_q | quo_q[63];
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = ovf_q ? {64{1'b1}} : quo_q;
endmodule

// ===== tb/relative_error_norm_accumulator_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// relative_error_norm_accumulator_unit_test
// self-checking bench: samples are driven in bursts with random gaps, the
// result channel stalls on a pattern of its own, and every result item is
// checked field by field against a local model of the norm accumulator
// ----------------------------------------------------------------------------
module relative_error_norm_accumulator_unit_test;
  import renacc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 3000000;
  localparam int unsigned SETTLE_WAIT  = 500;
  localparam logic [63:0] ALL_ONES     = {64{1'b1}};
  localparam logic [31:0] WEIGHT_ONE   = 32'h4000_0000;

  typedef enum logic { MODE_SCALAR = 1'b0, MODE_VECTOR = 1'b1 } mode_e;

  logic clk_i;
  logic rst_ni;

  renacc_cfg_if cfg_ch ();
  renacc_in_if  in_ch ();
  renacc_out_if out_ch ();

  relative_error_norm_accumulator_unit uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // model state
  mode_e       mode_q;
  logic [63:0] err_abs_acc, exact_abs_acc, err_sq_acc, exact_sq_acc;
  logic [63:0] err_peak_q, exact_peak_q;

  sample_t pending_samples[$];
  result_t expected_results[$];

  bit          failed;
  bit          in_fire;
  bit          drive_on;
  int unsigned cycle_cnt;
  int unsigned burst_left, gap_left;
  int unsigned stall_style;

  // --------------------------------------------------------------------------
  // arithmetic of the model
  // --------------------------------------------------------------------------
  function automatic logic [63:0] add_clip(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? ALL_ONES : s[63:0];
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0] x, r, b;
    x = n;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // floor(num * 2^f / den), clipped to all ones
  function automatic logic [63:0] ratio_fixed(logic [63:0] num, logic [63:0] den, int f);
    logic [63:0] q, r, res;
    logic [64:0] rr;
    q = num / den;
    r = num % den;
    if ((q >> (64 - f)) != 0) return ALL_ONES;
    res = q << f;
    for (int i = f - 1; i >= 0; i--) begin
      rr = {r, 1'b0};
      if (rr >= {1'b0, den}) begin
        rr = rr - {1'b0, den};
        res[i] = 1'b1;
      end
      r = rr[63:0];
    end
    return res;
  endfunction

  function automatic logic [63:0] weighted_sq(logic [63:0] m, logic [63:0] w);
    logic [63:0] sq, hi, lo;
    sq = m * m;
    hi = {32'd0, sq[63:32]} * w;
    lo = ({32'd0, sq[31:0]} * w) >> 30;
    if (hi[63:62] != 2'b00) return ALL_ONES;
    return add_clip(hi << 2, lo);
  endfunction

  function automatic logic [63:0] mag_of(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [31:0] narrow(logic [63:0] v);
    return (v[63:32] != 0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // updates the running sums and returns the result of one sample
  function automatic result_t accumulate_sample(sample_t s);
    result_t     r;
    longint      approx_v[3], exact_v[3], d[3];
    logic [63:0] esq, xsq, emag, xmag, w;
    int unsigned lanes;
    bit          fault;
    approx_v[0] = s.approx_x; approx_v[1] = s.approx_y; approx_v[2] = s.approx_z;
    exact_v[0]  = s.exact_x;  exact_v[1]  = s.exact_y;  exact_v[2]  = s.exact_z;
    lanes = (mode_q == MODE_VECTOR) ? USED_LANES : 1;
    esq = 0;
    xsq = 0;
    r = '0;
    for (int c = 0; c < 3; c++) begin
      d[c] = approx_v[c] - exact_v[c];
      if (d[c] > 64'sd2147483647) d[c] = 64'sd2147483647;
      if (d[c] < -64'sd2147483648) d[c] = -64'sd2147483648;
      if (c >= lanes) d[c] = 0;
    end
    r.error_x = d[0][31:0];
    r.error_y = d[1][31:0];
    r.error_z = d[2][31:0];
    if (mode_q == MODE_VECTOR) begin
      for (int c = 0; c < lanes; c++) begin
        esq = esq + mag_of(d[c]) * mag_of(d[c]);
        xsq = xsq + mag_of(exact_v[c]) * mag_of(exact_v[c]);
      end
      emag = root_floor(esq);
      xmag = root_floor(xsq);
    end else begin
      emag = mag_of(d[0]);
      xmag = mag_of(exact_v[0]);
    end
    w = {32'd0, s.weight};
    err_abs_acc   = add_clip(err_abs_acc, (emag * w) >> 14);
    exact_abs_acc = add_clip(exact_abs_acc, (xmag * w) >> 14);
    err_sq_acc    = add_clip(err_sq_acc, weighted_sq(emag, w));
    exact_sq_acc  = add_clip(exact_sq_acc, weighted_sq(xmag, w));
    if (emag > err_peak_q) err_peak_q = emag;
    if (xmag > exact_peak_q) exact_peak_q = xmag;
    if (s.last_sample) begin
      fault = 0;
      r.norms_valid = 1'b1;
      if (exact_abs_acc != 0) r.rel_l1 = narrow(ratio_fixed(err_abs_acc, exact_abs_acc, 16));
      else fault = 1;
      if (exact_sq_acc != 0)
        r.rel_l2 = narrow(root_floor(ratio_fixed(err_sq_acc, exact_sq_acc, 32)));
      else fault = 1;
      if (exact_peak_q != 0) r.rel_linf = narrow(ratio_fixed(err_peak_q, exact_peak_q, 16));
      else fault = 1;
      r.divide_fault = fault;
      err_abs_acc = 0; exact_abs_acc = 0; err_sq_acc = 0; exact_sq_acc = 0;
      err_peak_q = 0; exact_peak_q = 0;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic sample_t make_sample(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                          logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                                          logic [31:0] w, logic last);
    sample_t s;
    s.approx_x = ax; s.approx_y = ay; s.approx_z = az;
    s.exact_x  = ex; s.exact_y  = ey; s.exact_z  = ez;
    s.weight   = w;
    s.last_sample = last;
    return s;
  endfunction

  // modest values most often, with full range and the extremes mixed in
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'd0;
      3, 4, 5: return $urandom();
      default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'd0;
      2:       return WEIGHT_ONE;
      3, 4:    return $urandom();
      default: return $urandom_range(1, 32'h2000_0000);
    endcase
  endfunction

  task automatic queue_random_sets(int unsigned n_items);
    int unsigned left, len;
    bit zero_exact;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(1, 8);
      if (len > left) len = left;
      zero_exact = ($urandom_range(0, 15) == 0);
      for (int unsigned i = 0; i < len; i++) begin
        pending_samples.push_back(make_sample(pick_value(), pick_value(), pick_value(),
          zero_exact ? 32'd0 : pick_value(), zero_exact ? 32'd0 : pick_value(),
          zero_exact ? 32'd0 : pick_value(), pick_weight(), i == len - 1));
      end
      left = left - len;
    end
  endtask

  task automatic queue_directed();
    // saturating errors in both directions
    pending_samples.push_back(make_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
      32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0));
    pending_samples.push_back(make_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    // all zero set: every denominator zero
    pending_samples.push_back(make_sample(0, 0, 0, 0, 0, 0, 0, 1'b1));
    // zero weight but nonzero peaks: only the sums fault
    pending_samples.push_back(make_sample(32'h0001_0000, 32'h0002_0000, 0,
      32'h0003_0000, 0, 32'h0001_0000, 0, 1'b1));
    // exact value zero, error nonzero
    pending_samples.push_back(make_sample(32'h0005_0000, 32'h0005_0000, 32'h0005_0000,
      0, 0, 0, WEIGHT_ONE, 1'b1));
    // tiny exact, huge error: norm clips
    pending_samples.push_back(make_sample(32'h7FFF_FFFF, 0, 0, 32'h0000_0001, 0, 0,
      32'hFFFF_FFFF, 1'b1));
    // exact match: zero error
    pending_samples.push_back(make_sample(32'hFFFF_0000, 32'h1234_5678, 32'h0000_0001,
      32'hFFFF_0000, 32'h1234_5678, 32'h0000_0001, WEIGHT_ONE, 1'b0));
    pending_samples.push_back(make_sample(32'h0001_8000, 32'hFFFE_0000, 32'h0000_4000,
      32'h0001_0000, 32'hFFFF_0000, 32'h0000_2000, 32'h2000_0000, 1'b1));
    // negative exact peak exercises absolute value in Linf
    pending_samples.push_back(make_sample(32'hFFF0_0000, 0, 0, 32'hFFE0_0000, 0, 0,
      WEIGHT_ONE, 1'b1));
    // largest magnitudes with largest weight: squared sums saturate
    for (int i = 0; i < 4; i++)
      pending_samples.push_back(make_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, i == 3));
  endtask

  // block idle: nothing queued, nothing on the wire, nothing outstanding
  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_mode(mode_e m);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data.vector_mode <= m;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // clock, reset and timeout
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: accepted configuration, accepted samples, accepted results
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    result_t act, exp_r;
    in_fire = in_ch.valid && in_ch.ready;
    if (rst_ni && cfg_ch.valid && cfg_ch.ready)
      mode_q = mode_e'(cfg_ch.data.vector_mode);
    if (rst_ni && in_fire)
      expected_results.push_back(accumulate_sample(in_ch.data));
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      act = out_ch.data;
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected");
        failed = 1;
      end else begin
        exp_r = expected_results.pop_front();
        if (act.error_x !== exp_r.error_x) begin
          $error("error_x exp %0h got %0h", exp_r.error_x, act.error_x); failed = 1;
        end
        if (act.error_y !== exp_r.error_y) begin
          $error("error_y exp %0h got %0h", exp_r.error_y, act.error_y); failed = 1;
        end
        if (act.error_z !== exp_r.error_z) begin
          $error("error_z exp %0h got %0h", exp_r.error_z, act.error_z); failed = 1;
        end
        if (act.norms_valid !== exp_r.norms_valid) begin
          $error("norms_valid exp %0h got %0h", exp_r.norms_valid, act.norms_valid); failed = 1;
        end
        if (act.rel_l1 !== exp_r.rel_l1) begin
          $error("rel_l1 exp %0h got %0h", exp_r.rel_l1, act.rel_l1); failed = 1;
        end
        if (act.rel_l2 !== exp_r.rel_l2) begin
          $error("rel_l2 exp %0h got %0h", exp_r.rel_l2, act.rel_l2); failed = 1;
        end
        if (act.rel_linf !== exp_r.rel_linf) begin
          $error("rel_linf exp %0h got %0h", exp_r.rel_linf, act.rel_linf); failed = 1;
        end
        if (act.divide_fault !== exp_r.divide_fault) begin
          $error("divide_fault exp %0h got %0h", exp_r.divide_fault, act.divide_fault);
          failed = 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // sample driver: bursts of random length with random gaps
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (drive_on && (!in_ch.valid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        in_ch.data <= pending_samples.pop_front();
        in_ch.valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver: one of four stall styles, redrawn periodically
  always @(negedge clk_i) begin
    if (cycle_cnt % 700 == 0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= $urandom_range(0, 1);
      2:       out_ch.ready <= ($urandom_range(0, 7) != 0);
      default: out_ch.ready <= ((cycle_cnt % 97) > 60);
    endcase
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    mode_e plan[4];
    plan[0] = MODE_SCALAR; plan[1] = MODE_VECTOR; plan[2] = MODE_SCALAR; plan[3] = MODE_VECTOR;
    failed = 0; cycle_cnt = 0; in_fire = 0; drive_on = 0;
    burst_left = 1; gap_left = 0; stall_style = 0;
    mode_q = MODE_SCALAR;
    err_abs_acc = 0; exact_abs_acc = 0; err_sq_acc = 0; exact_sq_acc = 0;
    err_peak_q = 0; exact_peak_q = 0;
    rst_ni = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    drive_on = 1;
    for (int p = 0; p < 4; p++) begin
      write_mode(plan[p]);
      if (p < 2) queue_directed();
      queue_random_sets(p < 2 ? 280 : 320);
      wait_idle();
    end
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
